// ----- rtl/hstd_pkg.sv -----
package hstd_pkg;

  // nal unit types of interest
  localparam logic [4:0] NalSlice = 5'd1;
  localparam logic [4:0] NalIdr   = 5'd5;

  // default limit on slice header bits
  localparam int unsigned MaxHeaderBitsDefault = 48;

  // words held in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // frame type codes on the result
  typedef enum logic [1:0] {
    FT_NONE = 2'd0,
    FT_I    = 2'd1,
    FT_P    = 2'd2,
    FT_B    = 2'd3
  } frame_type_e;

  // one classified byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       is_one;
  } word_t;

  // exp-golomb parser state, info kept to the three bits that matter
  typedef struct packed {
    logic [5:0] bits_used;
    logic       code_index;
    logic       counting_zeros;
    logic [4:0] lead_zeros;
    logic [4:0] info_left;
    logic [2:0] info_value;
  } parse_t;

  // result of one parsed bit
  typedef struct packed {
    parse_t      st;
    logic        done;
    frame_type_e ft;
  } step_t;

  localparam parse_t ParseReset = '{
    bits_used:      6'd0,
    code_index:     1'b0,
    counting_zeros: 1'b1,
    lead_zeros:     5'd0,
    info_left:      5'd0,
    info_value:     3'd0
  };

  // slice_type code number to frame type
  function automatic frame_type_e slice_to_frame(logic [4:0] lead, logic [2:0] info);
    logic [3:0] v;
    frame_type_e ft;
    v  = ((4'd1 << lead[1:0]) - 4'd1) + {1'b0, info};
    ft = FT_NONE;
    if (v >= 4'd5) begin
      v = v - 4'd5;
    end
    if (lead > 5'd3) begin
      ft = FT_NONE;
    end else if (v == 4'd0) begin
      ft = FT_P;
    end else if (v == 4'd1) begin
      ft = FT_B;
    end else if (v == 4'd2) begin
      ft = FT_I;
    end
    return ft;
  endfunction

  // one bit through the exp-golomb reader
  function automatic step_t parse_bit(parse_t s, logic b, logic [6:0] max_bits);
    step_t r;
    logic  complete;
    r.st     = s;
    r.done   = 1'b0;
    r.ft     = FT_NONE;
    complete = 1'b0;
    if (({1'b0, s.bits_used} + 7'd1) > max_bits) begin
      r.done = 1'b1;
    end else begin
      r.st.bits_used = s.bits_used + 6'd1;
      if (s.counting_zeros) begin
        if (!b) begin
          if (s.lead_zeros >= 5'd31) begin
            r.done = 1'b1;
          end else begin
            r.st.lead_zeros = s.lead_zeros + 5'd1;
          end
        end else begin
          r.st.counting_zeros = 1'b0;
          r.st.info_left      = s.lead_zeros;
          r.st.info_value     = 3'd0;
          complete            = (s.lead_zeros == 5'd0);
        end
      end else begin
        r.st.info_value = {s.info_value[1:0], b};
        r.st.info_left  = s.info_left - 5'd1;
        complete        = (s.info_left == 5'd1);
      end
      if (complete) begin
        if (!s.code_index) begin
          r.st.code_index     = 1'b1;
          r.st.counting_zeros = 1'b1;
          r.st.lead_zeros     = 5'd0;
          r.st.info_value     = 3'd0;
        end else begin
          r.done = 1'b1;
          r.ft   = slice_to_frame(r.st.lead_zeros, r.st.info_value);
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/hstd_front.sv -----
module hstd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             word_valid_o,
  input  logic             word_stall_i,
  output hstd_pkg::word_t  word_o
);

  logic            valid_q;
  hstd_pkg::word_t word_q;
  logic            take;

  // stage is free when empty or when its word moves on
  assign take       = !valid_q || !word_stall_i;
  assign in_stall_o = !take;

  // register and classify the incoming byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      word_q.data    <= data_byte_i;
      word_q.last    <= last_byte_i;
      word_q.is_zero <= (data_byte_i == 8'h00);
      word_q.is_one  <= (data_byte_i == 8'h01);
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// ----- rtl/hstd_queue.sv -----
module hstd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  hstd_pkg::word_t  push_word_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output hstd_pkg::word_t  pop_word_o
);

  localparam int unsigned PtrW = $clog2(hstd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(hstd_pkg::QueueDepth + 1);

  hstd_pkg::word_t mem_q [hstd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_stall_o = (count_q == CntW'(hstd_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_word_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(hstd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(hstd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ----- rtl/hstd_back.sv -----
module hstd_back #(
  parameter int unsigned MAX_HEADER_BITS = hstd_pkg::MaxHeaderBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  output logic             word_pop_o,
  input  hstd_pkg::word_t  word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       frame_type_o
);

  localparam logic [6:0] MaxBits = 7'(MAX_HEADER_BITS);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SCAN,
    PH_PARSE,
    PH_DONE
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [1:0]            zero_run_q, zero_run_d;
  hstd_pkg::parse_t      parse_q, parse_d;
  logic                  out_valid_q;
  hstd_pkg::frame_type_e frame_q;
  logic                  advance, pop;
  logic                  have;
  hstd_pkg::frame_type_e ft;

  // a word is taken whenever the result register can be refilled
  assign advance    = !out_valid_q || !out_stall_i;
  assign pop        = advance && word_valid_i;
  assign word_pop_o = pop;

  // one byte through the detector
  always_comb begin
    hstd_pkg::step_t r;
    logic            found;
    logic            was_done;
    phase_d    = phase_q;
    zero_run_d = zero_run_q;
    parse_d    = parse_q;
    have       = 1'b0;
    ft         = hstd_pkg::FT_NONE;
    found      = 1'b0;
    was_done   = 1'b0;
    r          = '0;
    unique case (phase_q)
      PH_HEADER: begin
        if (word_i.data[4:0] == hstd_pkg::NalIdr) begin
          ft      = hstd_pkg::FT_I;
          have    = 1'b1;
          phase_d = PH_DONE;
        end else if (word_i.data[4:0] == hstd_pkg::NalSlice) begin
          parse_d = hstd_pkg::ParseReset;
          phase_d = PH_PARSE;
        end else begin
          zero_run_d = {1'b0, word_i.is_zero};
          phase_d    = PH_SCAN;
        end
      end
      PH_SCAN: begin
        // look for two or more zero bytes then 0x01
        if (word_i.is_zero) begin
          if (zero_run_q < 2'd2) begin
            zero_run_d = zero_run_q + 2'd1;
          end
        end else if (word_i.is_one && zero_run_q >= 2'd2) begin
          zero_run_d = 2'd0;
          phase_d    = PH_HEADER;
        end else begin
          zero_run_d = 2'd0;
        end
      end
      PH_PARSE: begin
        // eight bits, msb first, stop at the decision
        for (int k = 7; k >= 0; k--) begin
          if (!found) begin
            r       = hstd_pkg::parse_bit(parse_d, word_i.data[k], MaxBits);
            parse_d = r.st;
            if (r.done) begin
              found = 1'b1;
              ft    = r.ft;
            end
          end
        end
        if (found) begin
          have    = 1'b1;
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    // end of buffer: report if still undecided, then start over
    if (word_i.last) begin
      was_done   = (phase_d == PH_DONE) && !have;
      phase_d    = PH_HEADER;
      zero_run_d = 2'd0;
      parse_d    = hstd_pkg::ParseReset;
      if (!was_done && !have) begin
        ft   = hstd_pkg::FT_NONE;
        have = 1'b1;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      zero_run_q  <= 2'd0;
      parse_q     <= hstd_pkg::ParseReset;
      out_valid_q <= 1'b0;
      frame_q     <= hstd_pkg::FT_NONE;
    end else begin
      if (pop) begin
        phase_q    <= phase_d;
        zero_run_q <= zero_run_d;
        parse_q    <= parse_d;
      end
      if (advance) begin
        out_valid_q <= pop && have;
        frame_q     <= ft;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_type_o = frame_q;

endmodule

// ----- rtl/h264_slice_type_detect_unit.sv -----
// H.264 slice type detector. Feed the bytes of one buffer, NAL header byte
// first, one byte per word, with last_byte_i set on the final byte; exactly one
// frame_type_o word (0 none, 1 I, 2 P, 3 B) comes out per buffer, either as
// soon as the type is known or on the final byte. Non-slice NAL units are
// skipped up to the next start code; for a type-1 slice the first two
// Exp-Golomb codes are read, and more than MAX_HEADER_BITS header bits gives
// none. Sustained rate is one byte per cycle while nothing stalls: the back
// end decodes all eight bits of a byte at once. A result is registered once
// its byte has passed the input register, the queue and the result register,
// and either side may stall without stopping the other until the queue fills.
module h264_slice_type_detect_unit #(
  parameter int unsigned MAX_HEADER_BITS = hstd_pkg::MaxHeaderBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] frame_type_o
);

  logic            f_valid, f_stall;
  hstd_pkg::word_t f_word;
  logic            q_valid, q_pop;
  hstd_pkg::word_t q_word;

  // front: take and classify bytes
  hstd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .word_valid_o (f_valid),
    .word_stall_i (f_stall),
    .word_o       (f_word)
  );

  // decoupling queue
  hstd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_stall_o (f_stall),
    .push_word_i  (f_word),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_word_o   (q_word)
  );

  // back: start code scan, slice header parse, result
  hstd_back #(
    .MAX_HEADER_BITS (MAX_HEADER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (q_valid),
    .word_pop_o   (q_pop),
    .word_i       (q_word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_type_o (frame_type_o)
  );

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hstd_pkg::*;

  localparam int MaxBits    = MaxHeaderBitsDefault;
  localparam int CycleLimit = 200000;

  typedef enum logic [1:0] {
    SEEK_HEADER,
    SEEK_START,
    READ_SLICE,
    TYPE_KNOWN
  } seek_phase_e;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i  = 8'h00;
  logic       last_byte_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [1:0] frame_type_o;

  h264_slice_type_detect_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_type_o(frame_type_o)
  );

  // frame types still owed by the block, oldest first
  frame_type_e expected_frames[$];
  int          mismatches;
  int          cycles;
  int          idle_pct;
  int          stall_pct;
  int          bytes_sent;

  // buffer under construction
  logic [7:0]  buffer_bytes[$];
  logic        header_bits[$];

  // shadow of the detector state
  seek_phase_e sh_phase;
  logic [1:0]  sh_zero_run;
  logic [5:0]  sh_bits_used;
  logic        sh_code_index;
  logic        sh_counting;
  logic [4:0]  sh_lead;
  logic [4:0]  sh_info_left;
  logic [23:0] sh_info;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("h264_slice_type_detect_unit: mismatch");
      $finish;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    frame_type_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected frame type word %0d", frame_type_o);
        end
      end else begin
        want = expected_frames.pop_front();
        if (frame_type_o !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("frame type: expected %0d, got %0d", want, frame_type_o);
          end
        end
      end
    end
  end

  // slice header parse state back to its start
  task automatic start_slice_parse();
    sh_bits_used  = '0;
    sh_code_index = 1'b0;
    sh_counting   = 1'b1;
    sh_lead       = '0;
    sh_info_left  = '0;
    sh_info       = '0;
  endtask

  task automatic clear_shadow();
    sh_phase    = SEEK_HEADER;
    sh_zero_run = '0;
    start_slice_parse();
  endtask

  // slice_type code number to frame type
  function automatic frame_type_e slice_code_to_frame(logic [4:0] lead, logic [23:0] info);
    logic [31:0] code;
    if (lead > 5'd3) begin
      return FT_NONE;
    end
    code = ((32'd1 << lead) - 32'd1) + {16'd0, info[15:0]};
    if (code >= 32'd5) begin
      code = code - 32'd5;
    end
    case (code)
      32'd0:   return FT_P;
      32'd1:   return FT_B;
      32'd2:   return FT_I;
      default: return FT_NONE;
    endcase
  endfunction

  // one slice header bit through the exp-golomb reader
  task automatic golomb_bit(input logic b, output logic decided, output frame_type_e ft);
    logic complete;
    decided  = 1'b0;
    ft       = FT_NONE;
    complete = 1'b0;
    if (int'(sh_bits_used) + 1 > MaxBits) begin
      decided = 1'b1;
    end else begin
      sh_bits_used = sh_bits_used + 6'd1;
      if (sh_counting) begin
        if (!b) begin
          if (sh_lead >= 5'd31) begin
            decided = 1'b1;
          end else begin
            sh_lead = sh_lead + 5'd1;
          end
        end else begin
          sh_counting  = 1'b0;
          sh_info_left = sh_lead;
          sh_info      = '0;
          complete     = (sh_lead == 5'd0);
        end
      end else begin
        sh_info      = {sh_info[22:0], b};
        sh_info_left = sh_info_left - 5'd1;
        complete     = (sh_info_left == 5'd0);
      end
      if (!decided && complete) begin
        if (!sh_code_index) begin
          sh_code_index = 1'b1;
          sh_counting   = 1'b1;
          sh_lead       = '0;
          sh_info       = '0;
        end else begin
          decided = 1'b1;
          ft      = slice_code_to_frame(sh_lead, sh_info);
        end
      end
    end
  endtask

  // advance the shadow by one accepted byte, queue any frame type it yields
  task automatic predict_frame_type(input logic [7:0] b, input logic last);
    logic        have;
    logic        decided;
    frame_type_e ft;
    frame_type_e bit_ft;
    have = 1'b0;
    ft   = FT_NONE;
    case (sh_phase)
      SEEK_HEADER: begin
        if (b[4:0] == NalIdr) begin
          have     = 1'b1;
          ft       = FT_I;
          sh_phase = TYPE_KNOWN;
        end else if (b[4:0] == NalSlice) begin
          start_slice_parse();
          sh_phase = READ_SLICE;
        end else begin
          // the header byte itself may open a start code
          sh_zero_run = (b == 8'h00) ? 2'd1 : 2'd0;
          sh_phase    = SEEK_START;
        end
      end
      SEEK_START: begin
        if (b == 8'h00) begin
          if (sh_zero_run < 2'd2) begin
            sh_zero_run = sh_zero_run + 2'd1;
          end
        end else if (b == 8'h01 && sh_zero_run >= 2'd2) begin
          sh_zero_run = '0;
          sh_phase    = SEEK_HEADER;
        end else begin
          sh_zero_run = '0;
        end
      end
      READ_SLICE: begin
        for (int k = 7; k >= 0; k--) begin
          if (!have) begin
            golomb_bit(b[k], decided, bit_ft);
            if (decided) begin
              have     = 1'b1;
              ft       = bit_ft;
              sh_phase = TYPE_KNOWN;
            end
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      // a buffer already decided gives nothing more on its final byte
      if (sh_phase != TYPE_KNOWN || have) begin
        expected_frames.push_back(have ? ft : FT_NONE);
      end
      clear_shadow();
    end else if (have) begin
      expected_frames.push_back(ft);
    end
  endtask

  // one word through the input handshake
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_frame_type(b, last);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (buffer_bytes[i]) begin
      send_word(buffer_bytes[i], i == buffer_bytes.size() - 1);
    end
    buffer_bytes.delete();
  endtask

  // unsigned exp-golomb code of v
  task automatic put_ue(input int unsigned v);
    logic [31:0] n;
    int          lead;
    n    = v + 1;
    lead = 0;
    while ((n >> (lead + 1)) != 0) begin
      lead++;
    end
    for (int i = 0; i < lead; i++) begin
      header_bits.push_back(1'b0);
    end
    for (int i = lead; i >= 0; i--) begin
      header_bits.push_back(n[i]);
    end
  endtask

  // pad header bits to a byte boundary with random bits and pack them
  task automatic flush_bits();
    logic [7:0] b;
    while (header_bits.size() % 8 != 0) begin
      header_bits.push_back(1'($urandom_range(0, 1)));
    end
    while (header_bits.size() != 0) begin
      for (int i = 7; i >= 0; i--) begin
        b[i] = header_bits.pop_front();
      end
      buffer_bytes.push_back(b);
    end
  endtask

  task automatic add_random_bytes(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) begin
      buffer_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_idr_unit();
    buffer_bytes.push_back({3'($urandom_range(0, 7)), NalIdr});
    add_random_bytes(0, 3);
  endtask

  task automatic add_slice_unit();
    int          r;
    int unsigned lead;
    buffer_bytes.push_back({3'($urandom_range(0, 7)), NalSlice});
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put_ue($urandom_range(0, 300));
    end else if (r < 85) begin
      // long first_mb_in_slice, pushes against the header bit limit
      lead = $urandom_range(14, 24);
      put_ue((32'd1 << lead) - 1 + $urandom_range(0, (32'd1 << lead) - 1));
    end else begin
      // zero run near or past what a code can hold
      repeat ($urandom_range(28, 34)) begin
        header_bits.push_back(1'b0);
      end
      header_bits.push_back(1'b1);
    end
    if ($urandom_range(0, 99) < 80) begin
      put_ue($urandom_range(0, 9));
    end else begin
      put_ue($urandom_range(10, 300));
    end
    flush_bits();
    add_random_bytes(0, 2);
  endtask

  // non-slice unit closed by a three or four byte start code
  task automatic add_skipped_unit();
    logic [7:0] hdr;
    if ($urandom_range(0, 5) == 0) begin
      hdr = 8'h00;
    end else begin
      do begin
        hdr = 8'($urandom_range(0, 255));
      end while (hdr[4:0] == NalSlice || hdr[4:0] == NalIdr);
    end
    buffer_bytes.push_back(hdr);
    add_random_bytes(0, 4);
    if ($urandom_range(0, 1)) begin
      buffer_bytes.push_back(8'h00);
    end
    buffer_bytes.push_back(8'h00);
    buffer_bytes.push_back(8'h00);
    buffer_bytes.push_back(8'h01);
  endtask

  task automatic test_idr_frames();
    buffer_bytes = {8'h65};
    send_buffer();
    buffer_bytes = {8'h05, 8'hff};
    send_buffer();
  endtask

  task automatic test_slice_types();
    // P, B, I, slice type three, slice type seven
    buffer_bytes = {8'h41, 8'hc0};
    send_buffer();
    buffer_bytes = {8'h21, 8'ha0};
    send_buffer();
    buffer_bytes = {8'h61, 8'hb0};
    send_buffer();
    buffer_bytes = {8'h41, 8'h90};
    send_buffer();
    buffer_bytes = {8'h41, 8'h88};
    send_buffer();
    // endless zero run, then a byte after the decision
    buffer_bytes = {8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff};
    send_buffer();
  endtask

  task automatic test_start_code_skip();
    buffer_bytes = {8'h06, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
    send_buffer();
    // zero header byte starts the start code
    buffer_bytes = {8'h00, 8'h00, 8'h01, 8'h25};
    send_buffer();
  endtask

  task automatic test_early_end();
    buffer_bytes = {8'h41};
    send_buffer();
    buffer_bytes = {8'h07, 8'h00, 8'h00, 8'h01};
    send_buffer();
  endtask

  // sender holds off until every owed word has come back
  task automatic test_drain_pause();
    add_slice_unit();
    send_buffer();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_frames.size() != 0);
  endtask

  task automatic test_random_mix(input int idle, input int stall, input int goal);
    int r;
    int cut;
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = bytes_sent + goal;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_idr_unit();
      end else if (r < 55) begin
        add_slice_unit();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 2)) begin
          add_skipped_unit();
        end
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 2) != 0) begin
            add_slice_unit();
          end else begin
            add_idr_unit();
          end
        end
      end else begin
        add_random_bytes(1, 6);
      end
      // cut some buffers short
      if ($urandom_range(0, 9) == 0 && buffer_bytes.size() > 1) begin
        cut          = $urandom_range(1, buffer_bytes.size() - 1);
        buffer_bytes = buffer_bytes[0:cut-1];
      end
      send_buffer();
    end
  endtask

  initial begin
    mismatches = 0;
    cycles     = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    bytes_sent = 0;
    clear_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idr_frames();
    test_slice_types();
    test_start_code_skip();
    test_early_end();
    test_random_mix(0, 0, 400);
    test_drain_pause();
    test_random_mix(59, 0, 400);
    test_random_mix(0, 59, 400);
    test_drain_pause();
    test_random_mix(32, 32, 400);

    // drain, then give stray words time to show up
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_frames.size() != 0);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("h264_slice_type_detect_unit: match");
    end else begin
      $display("h264_slice_type_detect_unit: mismatch");
    end
    $finish;
  end

endmodule
